// ===== rtl/core/rmt_pkg.sv =====
`default_nettype none

package rmt_pkg;

    localparam int LEAVES     = 1024;
    localparam int VALUE_BITS = 20;
    localparam int LEAF_BITS  = $clog2(LEAVES);
    localparam int NODE_BITS  = LEAF_BITS + 1;
    localparam int NODE_COUNT = 2 * LEAVES;

    // action codes
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [NODE_BITS-1:0]  node_t;

    // status of the range walker toward the sequencer
    typedef struct packed {
        logic   active;
        node_t  addr_lo;
        node_t  addr_hi;
        value_t best;
    } qry_stat_t;

    function automatic value_t max_val(input value_t a, input value_t b);
        max_val = (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rmt_ram.sv =====
`default_nettype none

module rmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/rmt_query.sv =====
`default_nettype none

module rmt_query
    import rmt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic                 step,
    input  wire logic [LEAF_BITS-1:0] range_left,
    input  wire logic [LEAF_BITS-1:0] range_right,
    input  wire value_t               rd_data_lo,
    input  wire value_t               rd_data_hi,
    output qry_stat_t                 stat
);

    node_t  lo_reg, lo_next;
    node_t  hi_reg, hi_next;
    value_t best_reg, best_next;
    logic   pend_lo_reg, pend_lo_next;
    logic   pend_hi_reg, pend_hi_next;

    logic                 active;
    logic [NODE_BITS:0]   lo_inc;
    node_t                hi_dec;
    value_t               take_lo;
    value_t               take_hi;

    assign active = (lo_reg <= hi_reg);
    assign lo_inc = {1'b0, lo_reg} + {{NODE_BITS{1'b0}}, 1'b1};
    assign hi_dec = hi_reg - node_t'(1);

    // fold in the nodes read on the previous step
    assign take_lo   = pend_lo_reg ? rd_data_lo : '0;
    assign take_hi   = pend_hi_reg ? rd_data_hi : '0;
    assign best_next = max_val(best_reg, max_val(take_lo, take_hi));

    // bounds walk one level up per step
    always_comb
    begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pend_lo_next = pend_lo_reg;
        pend_hi_next = pend_hi_reg;
        if (load)
        begin
            lo_next      = {1'b1, range_left};
            hi_next      = {1'b1, range_right};
            pend_lo_next = 1'b0;
            pend_hi_next = 1'b0;
        end
        else if (step)
        begin
            if (active)
            begin
                pend_lo_next = lo_reg[0];
                pend_hi_next = ~hi_reg[0];
                lo_next      = lo_reg[0] ? lo_inc[NODE_BITS:1] : {1'b0, lo_reg[NODE_BITS-1:1]};
                hi_next      = hi_reg[0] ? {1'b0, hi_reg[NODE_BITS-1:1]}
                                         : {1'b0, hi_dec[NODE_BITS-1:1]};
            end
            else
            begin
                pend_lo_next = 1'b0;
                pend_hi_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_lo_reg <= 1'b0;
            pend_hi_reg <= 1'b0;
        end
        else
        begin
            pend_lo_reg <= pend_lo_next;
            pend_hi_reg <= pend_hi_next;
        end
    end

    // bounds and running maximum
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (load)
        begin
            best_reg <= '0;
        end
        else if (step)
        begin
            best_reg <= best_next;
        end
    end

    assign stat.active  = active;
    assign stat.addr_lo = lo_reg;
    assign stat.addr_hi = hi_reg;
    assign stat.best    = best_next;

endmodule

`default_nettype wire

// ===== rtl/core/range_max_tree.sv =====
// range_max_tree: max segment tree over LEAVES leaves in one two-read RAM
// update: busy while the leaf and each ancestor up to the root are written, one tree level written per cycle
// query: busy until the two bounds cross, one level of both bounds per cycle,
// result_valid pulses for one cycle as busy falls; the receiver cannot stall
// one item at a time: start is taken only while busy is low
// reset: a clearing pass zeroes all 2*LEAVES nodes, busy stays high meanwhile
`default_nettype none

module range_max_tree
    import rmt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  action,
    input  wire logic [LEAF_BITS-1:0]  leaf_index,
    input  wire logic [VALUE_BITS-1:0] leaf_value,
    input  wire logic [LEAF_BITS-1:0]  range_left,
    input  wire logic [LEAF_BITS-1:0]  range_right,
    output logic                       result_valid,
    output logic [VALUE_BITS-1:0]      range_maximum
);

    typedef enum logic [4:0] {
        ST_CLEAR     = 5'b00001,
        ST_IDLE      = 5'b00010,
        ST_UPD_LEAF  = 5'b00100,
        ST_UPD_CLIMB = 5'b01000,
        ST_QUERY     = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    node_t  node_reg, node_next;
    value_t val_reg, val_next;
    node_t  clr_reg, clr_next;
    logic   result_valid_reg, result_valid_next;
    value_t range_maximum_reg;

    logic      accept;
    logic      wr_en;
    node_t     wr_addr;
    value_t    wr_data;
    node_t     rd_addr_a;
    value_t    rd_data_a;
    value_t    rd_data_b;
    value_t    climb_val;
    logic      q_load;
    logic      q_step;
    qry_stat_t q_stat;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && (state_reg == ST_IDLE);
    assign climb_val = max_val(val_reg, rd_data_a);
    assign q_load    = accept && (action == ACT_QUERY);
    assign q_step    = (state_reg == ST_QUERY);

    // sequencer and memory port selection
    always_comb
    begin
        state_next        = state_reg;
        node_next         = node_reg;
        val_next          = val_reg;
        clr_next          = clr_reg;
        result_valid_next = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = node_reg;
        wr_data           = val_reg;
        rd_addr_a         = node_reg ^ node_t'(1);
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + node_t'(1);
                if (clr_reg == node_t'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_UPDATE)
                    begin
                        node_next  = {1'b1, leaf_index};
                        val_next   = leaf_value;
                        state_next = ST_UPD_LEAF;
                    end
                    else
                    begin
                        state_next = ST_QUERY;
                    end
                end
            end
            ST_UPD_LEAF:
            begin
                // write the leaf, fetch its sibling
                wr_en      = 1'b1;
                node_next  = node_reg >> 1;
                state_next = ST_UPD_CLIMB;
            end
            ST_UPD_CLIMB:
            begin
                // parent takes the larger child, fetch the parent's sibling
                wr_en     = 1'b1;
                wr_data   = climb_val;
                val_next  = climb_val;
                node_next = node_reg >> 1;
                if (node_reg == node_t'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QUERY:
            begin
                rd_addr_a = q_stat.addr_lo;
                if (!q_stat.active)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // update walk and result payload
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        val_reg  <= val_next;
        if (result_valid_next)
        begin
            range_maximum_reg <= q_stat.best;
        end
    end

    assign result_valid  = result_valid_reg;
    assign range_maximum = range_maximum_reg;

    rmt_query u_query (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (q_load),
        .step        (q_step),
        .range_left  (range_left),
        .range_right (range_right),
        .rd_data_lo  (rd_data_a),
        .rd_data_hi  (rd_data_b),
        .stat        (q_stat)
    );

    rmt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (q_stat.addr_hi),
        .rd_data_b (rd_data_b)
    );

endmodule

`default_nettype wire
